@@ design/usmp_pkg.sv @@
`timescale 1ns / 1ps

package usmp_pkg;

  localparam int WORD_LEN = 5;
  localparam int WINDOW_DEPTH = 4;
  localparam int WORD_COUNT = 8;
  localparam int FILL_BITS = 3;
  localparam int POLL_COUNT_BITS_DEF = 16;
  localparam int MAX_IDLE_BITS = 16;
  localparam logic [MAX_IDLE_BITS-1:0] MAX_IDLE_POLLS_RST = 16'd2;

  // Action codes of an input item.
  localparam logic [1:0] ACT_BYTE = 2'd0;
  localparam logic [1:0] ACT_POLL = 2'd1;
  localparam logic [1:0] ACT_LINK_ERR = 2'd2;

  // Status word codes.
  localparam logic [2:0] CODE_BUFRD = 3'd0;
  localparam logic [2:0] CODE_ALARM = 3'd1;
  localparam logic [2:0] CODE_DC_OK = 3'd2;
  localparam logic [2:0] CODE_DC_LO = 3'd3;
  localparam logic [2:0] CODE_BAT_OFF = 3'd4;
  localparam logic [2:0] CODE_BAT_ON = 3'd5;
  localparam logic [2:0] CODE_CHG_HI = 3'd6;
  localparam logic [2:0] CODE_CHG_LO = 3'd7;

  // Five characters, oldest in the top byte.
  typedef logic [8*WORD_LEN-1:0] word_t;

  localparam word_t STATUS_WORDS [WORD_COUNT] = '{
    "BUFRD", "ALARM", "DC_OK", "DC_LO", "*****", "*BAT*", "BA>85", "BA<85"
  };

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] received_byte;
  } in_item_t;

  typedef struct packed {
    logic       message_matched;
    logic [2:0] message_code;
    logic       data_stale;
    logic       on_battery_status;
    logic       low_battery;
    logic       charge_above_85;
    logic       input_voltage_low;
    logic       battery_mode;
  } out_item_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] code;
  } match_t;

endpackage

@@ design/usmp_word_match.sv @@
`timescale 1ns / 1ps

module usmp_word_match
  import usmp_pkg::*;
(
  input  word_t  cand,
  output match_t match
);

  // All eight words are compared in parallel; the lowest index wins.
  always_comb begin
    match = '0;
    for (int i = WORD_COUNT - 1; i >= 0; i--) begin
      if (cand == STATUS_WORDS[i]) begin
        match.hit  = 1'b1;
        match.code = 3'(i);
      end
    end
  end

endmodule

@@ design/ups_status_message_parser_unit.sv @@
`timescale 1ns / 1ps
// Status word parser for a serial UPS link.
// Input channel (in_valid / in_stall / in_data): one item per serial character,
// poll tick or link error. Result channel (out_valid / out_stall / out_data):
// exactly one result item per input item, showing the status after that item.
// Configuration channel (cfg_valid / cfg_ready / cfg_max_idle_polls): writes the
// idle poll limit; cfg_ready is always high. Write it only while the block is idle.
// Each item is decoded, matched against the eight status words and folded into
// the flags in the cycle it is accepted, and its result sits in the output
// register at the next edge. Throughput is one item per cycle while the receiver
// does not stall; the single output register is the only stage.
// When the receiver stalls with a result pending, in_stall rises in the same
// cycle and no item is taken until the result register is free again.
// Reset (rst_n low, synchronous) empties the window, clears all flags and the idle
// poll count, drops any pending result, and sets the idle limit to 2.
module ups_status_message_parser_unit
  import usmp_pkg::*;
#(
  parameter int POLL_COUNT_BITS = POLL_COUNT_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  in_item_t                 in_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output out_item_t                out_data,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [MAX_IDLE_BITS-1:0] cfg_max_idle_polls
);

  localparam int CMP_W = (POLL_COUNT_BITS > MAX_IDLE_BITS) ? POLL_COUNT_BITS : MAX_IDLE_BITS;

  logic [7:0]                 window_r [WINDOW_DEPTH];
  logic [7:0]                 window_nxt [WINDOW_DEPTH];
  logic [FILL_BITS-1:0]       fill_r, fill_nxt;
  logic                       alarm_r, alarm_nxt;
  logic                       in_low_r, in_low_nxt;
  logic                       battery_r, battery_nxt;
  logic                       chg_high_r, chg_high_nxt;
  logic                       seen_r, seen_nxt;
  logic [POLL_COUNT_BITS-1:0] count_r, count_nxt;
  logic [MAX_IDLE_BITS-1:0]   max_idle_r;
  logic                       out_valid_r;
  out_item_t                  out_data_r, out_data_nxt;

  logic                       in_acc;
  word_t                      cand;
  match_t                     match;
  logic                       window_full;

  assign in_stall  = out_valid_r && out_stall;
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  assign window_full = (fill_r == FILL_BITS'(WINDOW_DEPTH));
  assign cand = {window_r[0], window_r[1], window_r[2], window_r[3], in_data.received_byte};

  usmp_word_match u_match (
    .cand  (cand),
    .match (match)
  );

  always_comb begin
    window_nxt   = window_r;
    fill_nxt     = fill_r;
    alarm_nxt    = alarm_r;
    in_low_nxt   = in_low_r;
    battery_nxt  = battery_r;
    chg_high_nxt = chg_high_r;
    seen_nxt     = seen_r;
    count_nxt    = count_r;
    out_data_nxt = '0;

    case (in_data.action)
      ACT_BYTE: begin
        if (!window_full) begin
          window_nxt[fill_r[1:0]] = in_data.received_byte;
          fill_nxt = fill_r + FILL_BITS'(1);
        end else if (match.hit) begin
          out_data_nxt.message_matched = 1'b1;
          out_data_nxt.message_code    = match.code;
          seen_nxt = 1'b1;
          fill_nxt = '0;
          case (match.code)
            CODE_BUFRD:   alarm_nxt    = 1'b0;
            CODE_ALARM:   alarm_nxt    = 1'b1;
            CODE_DC_OK:   in_low_nxt   = 1'b0;
            CODE_DC_LO:   in_low_nxt   = 1'b1;
            CODE_BAT_OFF: battery_nxt  = 1'b0;
            CODE_BAT_ON:  battery_nxt  = 1'b1;
            CODE_CHG_HI:  chg_high_nxt = 1'b1;
            default:      chg_high_nxt = 1'b0;
          endcase
        end else begin
          // Drop the oldest character; the window keeps the last four.
          for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
            window_nxt[i] = window_r[i+1];
          end
          window_nxt[WINDOW_DEPTH-1] = in_data.received_byte;
        end
      end
      ACT_POLL: begin
        if (seen_r) begin
          count_nxt = '0;
          seen_nxt  = 1'b0;
        end else if (count_r != '1) begin
          count_nxt = count_r + POLL_COUNT_BITS'(1);
        end
      end
      ACT_LINK_ERR: begin
        fill_nxt = '0;
      end
      default: begin
      end
    endcase

    out_data_nxt.data_stale        = CMP_W'(count_nxt) > CMP_W'(max_idle_r);
    out_data_nxt.on_battery_status = in_low_nxt | battery_nxt;
    out_data_nxt.low_battery       = alarm_nxt;
    out_data_nxt.charge_above_85   = chg_high_nxt;
    out_data_nxt.input_voltage_low = in_low_nxt;
    out_data_nxt.battery_mode      = battery_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      alarm_r     <= 1'b0;
      in_low_r    <= 1'b0;
      battery_r   <= 1'b0;
      chg_high_r  <= 1'b0;
      seen_r      <= 1'b0;
      count_r     <= '0;
      max_idle_r  <= MAX_IDLE_POLLS_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        max_idle_r <= cfg_max_idle_polls;
      end
      if (in_acc) begin
        fill_r     <= fill_nxt;
        alarm_r    <= alarm_nxt;
        in_low_r   <= in_low_nxt;
        battery_r  <= battery_nxt;
        chg_high_r <= chg_high_nxt;
        seen_r     <= seen_nxt;
        count_r    <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      window_r   <= window_nxt;
      out_data_r <= out_data_nxt;
    end
  end

`ifndef ASSERT_OFF
  assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_BITS'(WINDOW_DEPTH))
    else $error("window fill count beyond window depth");

  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r)
    else $error("input stalled with no result pending");

  assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.action == ACT_BYTE && window_full && match.hit)
    |=> (fill_r == '0 && seen_r && out_valid_r && out_data_r.message_matched))
    else $error("matched word did not empty the window and mark activity");

  assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.action == ACT_POLL && seen_r) |=> (count_r == '0 && !seen_r))
    else $error("poll after a matched word did not restart the idle count");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.on_battery_status ==
                     (out_data_r.input_voltage_low | out_data_r.battery_mode)))
    else $error("on-battery status disagrees with its flags");
`endif

endmodule
